/* rtl/core/ragged_two_level_index_mapper_defines.svh */
// Assertion macros for the index mapper.
// Each use stands on a line of its own and carries its own label.
`ifndef RAGGED_TWO_LEVEL_INDEX_MAPPER_DEFINES_SVH
`define RAGGED_TWO_LEVEL_INDEX_MAPPER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RTLIM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rtlim: same-cycle check failed");
// Next-cycle implication.
`define RTLIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtlim: next-cycle check failed");
`else
`define RTLIM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RTLIM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/rtlim_pkg.sv */
`timescale 1ns / 1ps

package rtlim_pkg;

	localparam int MAX_ATOMS_DEF     = 256;
	localparam int MAX_SHELLS_DEF    = 1024;
	localparam int FUNCTION_BITS_DEF = 16;

	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 10;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR      = 3'd0,
		MODE_ADD_ATOM   = 3'd1,
		MODE_ADD_SHELL  = 3'd2,
		MODE_FIND_FUNC  = 3'd3,
		MODE_FIND_SHELL = 3'd4,
		MODE_TO_GLOBAL  = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// bits to index n entries
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// bits to hold a count from 0 to n
	function automatic int cnt_w(input int n);
		return (n > 0) ? $clog2(n + 1) : 1;
	endfunction

endpackage

/* rtl/core/rtlim_ram.sv */
`timescale 1ns / 1ps

module rtlim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [rtlim_pkg::idx_w(DEPTH)-1:0]   addr,
	input  logic [WIDTH-1:0]                     wdata,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first, registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/rtlim_seq.sv */
`timescale 1ns / 1ps
`include "ragged_two_level_index_mapper_defines.svh"

module rtlim_seq #(
	parameter int MAX_ATOMS     = rtlim_pkg::MAX_ATOMS_DEF,
	parameter int MAX_SHELLS    = rtlim_pkg::MAX_SHELLS_DEF,
	parameter int FUNCTION_BITS = rtlim_pkg::FUNCTION_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic [rtlim_pkg::MODE_W-1:0]              mode,
	input  logic [rtlim_pkg::idx_w(MAX_ATOMS)-1:0]    atom_index,
	input  logic [rtlim_pkg::idx_w(MAX_SHELLS)-1:0]   shell_index,
	input  logic [FUNCTION_BITS-1:0]                  function_index,
	input  logic [rtlim_pkg::COUNT_W-1:0]             count,
	output logic                                      done,
	output logic [rtlim_pkg::STATUS_W-1:0]            status,
	output logic [rtlim_pkg::idx_w(MAX_ATOMS)-1:0]    atom_found,
	output logic [rtlim_pkg::idx_w(MAX_SHELLS)-1:0]   shell_local,
	output logic [rtlim_pkg::idx_w(MAX_SHELLS)-1:0]   shell_global,
	output logic [FUNCTION_BITS-1:0]                  function_local,
	output logic [FUNCTION_BITS-1:0]                  function_global,
	output logic [rtlim_pkg::cnt_w(MAX_SHELLS)-1:0]   shells_of_atom,
	output logic [rtlim_pkg::COUNT_W-1:0]             functions_of_shell,
	output logic [rtlim_pkg::cnt_w(MAX_ATOMS)-1:0]    atoms_total,
	output logic [rtlim_pkg::cnt_w(MAX_SHELLS)-1:0]   shells_total,
	output logic [FUNCTION_BITS-1:0]                  functions_total,
	output logic                                      ss_we,
	output logic [rtlim_pkg::idx_w(MAX_ATOMS)-1:0]    ss_addr,
	output logic [rtlim_pkg::cnt_w(MAX_SHELLS)-1:0]   ss_wdata,
	input  logic [rtlim_pkg::cnt_w(MAX_SHELLS)-1:0]   ss_rdata,
	output logic                                      fs_we,
	output logic [rtlim_pkg::idx_w(MAX_SHELLS)-1:0]   fs_addr,
	output logic [FUNCTION_BITS-1:0]                  fs_wdata,
	input  logic [FUNCTION_BITS-1:0]                  fs_rdata
);

	import rtlim_pkg::*;

	localparam int AW    = idx_w(MAX_ATOMS);
	localparam int ACW   = cnt_w(MAX_ATOMS);
	localparam int SW    = idx_w(MAX_SHELLS);
	localparam int SCW   = cnt_w(MAX_SHELLS);
	localparam int FW    = FUNCTION_BITS;
	localparam int CW    = COUNT_W;
	localparam int IW    = (AW > SW) ? AW : SW;
	localparam int KW    = (SCW > FW) ? SCW : FW;
	localparam int SSUMW = ((SCW > CW) ? SCW : CW) + 1;
	localparam int FSUMW = ((FW > CW) ? FW : CW) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SINIT,
		S_SRCH,
		S_F0,
		S_F1,
		S_F2,
		S_FIN
	} state_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [SW-1:0]     si_q;
	logic [FW-1:0]     fi_q;
	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     lo_q;
	logic [IW-1:0]     hi_q;
	logic [IW-1:0]     mid_q;
	logic [KW-1:0]     key_q;
	logic              tbl_q;     // search target: 1 function sums, 0 shell sums
	logic              phase_q;   // second fetch of local-to-global
	logic [AW-1:0]     a_q;
	logic [SW-1:0]     s_q;
	logic [SCW-1:0]    ss_top_q;
	logic [SCW-1:0]    ss_base_q;
	logic [FW-1:0]     fs_top_q;
	logic [FW-1:0]     fs_base_q;
	logic [ACW-1:0]    atom_count_q;
	logic [SCW-1:0]    shell_count_q;
	logic [SCW-1:0]    app_q;
	logic [FW-1:0]     ftot_q;
	status_t           res_status_q;
	logic [AW-1:0]     res_atom_q;
	logic [SW-1:0]     res_sloc_q;
	logic [SW-1:0]     res_sglob_q;
	logic [FW-1:0]     res_floc_q;
	logic [FW-1:0]     res_fglob_q;
	logic [SCW-1:0]    res_soa_q;
	logic [CW-1:0]     res_fos_q;
	logic              done_q;

	logic [SSUMW-1:0]  add_ssum;
	logic [FSUMW-1:0]  add_fsum;
	logic              full_atom;
	logic              full_shell;
	logic [KW-1:0]     srch_data;
	logic              gt;
	logic [IW-1:0]     nlo;
	logic [IW-1:0]     nhi;
	logic [IW-1:0]     nmid;
	logic [IW-1:0]     init_mid;
	logic [IW-1:0]     srch_addr;
	logic              srch_fin;
	logic [IW-1:0]     srch_idx;
	logic [SCW-1:0]    fin_soa;
	logic [SW-1:0]     fin_sloc;
	logic [FW-1:0]     fin_fos;
	logic [FW-1:0]     fin_fos_v;
	logic              s_hit;

	assign add_ssum   = SSUMW'(shell_count_q) + SSUMW'(count);
	assign add_fsum   = FSUMW'(ftot_q) + FSUMW'(count);
	assign full_atom  = (atom_count_q >= ACW'(MAX_ATOMS)) || (add_ssum > SSUMW'(MAX_SHELLS));
	assign full_shell = (app_q >= shell_count_q) || (app_q >= SCW'(MAX_SHELLS)) ||
		(add_fsum[FSUMW-1:FW] != '0);

	// binary search step: find the first entry above the key
	assign srch_data = tbl_q ? KW'(fs_rdata) : KW'(ss_rdata);
	assign gt        = srch_data > key_q;
	assign nlo       = gt ? lo_q : mid_q + 1'b1;
	assign nhi       = gt ? mid_q : hi_q;
	assign nmid      = IW'(({1'b0, nlo} + {1'b0, nhi}) >> 1);
	assign init_mid  = IW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign srch_addr = (state_q == S_SINIT) ? init_mid : nmid;
	assign srch_fin  = (state_q == S_SINIT) ? (lo_q == hi_q) : !(nlo < nhi);
	assign srch_idx  = (state_q == S_SINIT) ? lo_q : nlo;

	assign fin_soa   = ss_top_q - ss_base_q;
	assign fin_sloc  = SW'(SCW'(s_q) - ss_base_q);
	assign fin_fos   = fs_top_q - fs_base_q;
	assign s_hit     = SCW'(s_q) < app_q;
	assign fin_fos_v = s_hit ? fin_fos : '0;

	always_comb begin
		ss_we    = 1'b0;
		ss_addr  = '0;
		ss_wdata = SCW'(add_ssum);
		fs_we    = 1'b0;
		fs_addr  = '0;
		fs_wdata = FW'(ftot_q + FW'(cnt_q));
		unique case (state_q)
			S_IDLE: begin
				ss_we   = start && (mode == MODE_ADD_ATOM) && !full_atom;
				ss_addr = AW'(atom_count_q);
			end
			S_SINIT, S_SRCH: begin
				if (tbl_q) begin
					fs_addr = SW'(srch_addr);
				end else begin
					ss_addr = AW'(srch_addr);
				end
			end
			S_F0: begin
				ss_addr = a_q;
				fs_addr = s_q;
			end
			S_F1: begin
				ss_addr = a_q - 1'b1;
				fs_addr = s_q - 1'b1;
			end
			S_FIN: begin
				fs_we   = (mode_q == MODE_ADD_SHELL);
				fs_addr = s_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mode_q        <= MODE_CLEAR;
			si_q          <= '0;
			fi_q          <= '0;
			cnt_q         <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
			mid_q         <= '0;
			key_q         <= '0;
			tbl_q         <= 1'b0;
			phase_q       <= 1'b0;
			a_q           <= '0;
			s_q           <= '0;
			ss_top_q      <= '0;
			ss_base_q     <= '0;
			fs_top_q      <= '0;
			fs_base_q     <= '0;
			atom_count_q  <= '0;
			shell_count_q <= '0;
			app_q         <= '0;
			ftot_q        <= '0;
			res_status_q  <= ST_OK;
			res_atom_q    <= '0;
			res_sloc_q    <= '0;
			res_sglob_q   <= '0;
			res_floc_q    <= '0;
			res_fglob_q   <= '0;
			res_soa_q     <= '0;
			res_fos_q     <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q       <= mode_t'(mode);
						si_q         <= shell_index;
						fi_q         <= function_index;
						cnt_q        <= count;
						lo_q         <= '0;
						phase_q      <= 1'b0;
						res_status_q <= ST_OK;
						res_atom_q   <= '0;
						res_sloc_q   <= '0;
						res_sglob_q  <= '0;
						res_floc_q   <= '0;
						res_fglob_q  <= '0;
						res_soa_q    <= '0;
						res_fos_q    <= '0;
						unique case (mode)
							MODE_CLEAR: begin
								atom_count_q  <= '0;
								shell_count_q <= '0;
								app_q         <= '0;
								ftot_q        <= '0;
								done_q        <= 1'b1;
							end
							MODE_ADD_ATOM: begin
								done_q <= 1'b1;
								if (full_atom) begin
									res_status_q <= ST_FULL;
								end else begin
									res_atom_q    <= AW'(atom_count_q);
									res_sglob_q   <= SW'(shell_count_q);
									res_soa_q     <= SCW'(count);
									shell_count_q <= SCW'(add_ssum);
									atom_count_q  <= atom_count_q + 1'b1;
								end
							end
							MODE_ADD_SHELL: begin
								if (full_shell) begin
									res_status_q <= ST_FULL;
									done_q       <= 1'b1;
								end else begin
									s_q     <= SW'(app_q);
									key_q   <= KW'(app_q);
									tbl_q   <= 1'b0;
									hi_q    <= IW'(atom_count_q - 1'b1);
									state_q <= S_SINIT;
								end
							end
							MODE_FIND_FUNC: begin
								if (function_index >= ftot_q) begin
									res_status_q <= ST_RANGE;
									done_q       <= 1'b1;
								end else begin
									key_q   <= KW'(function_index);
									tbl_q   <= 1'b1;
									hi_q    <= IW'(app_q - 1'b1);
									state_q <= S_SINIT;
								end
							end
							MODE_FIND_SHELL: begin
								if (SCW'(shell_index) >= shell_count_q) begin
									res_status_q <= ST_RANGE;
									done_q       <= 1'b1;
								end else begin
									s_q     <= shell_index;
									key_q   <= KW'(shell_index);
									tbl_q   <= 1'b0;
									hi_q    <= IW'(atom_count_q - 1'b1);
									state_q <= S_SINIT;
								end
							end
							MODE_TO_GLOBAL: begin
								if (ACW'(atom_index) >= atom_count_q) begin
									res_status_q <= ST_RANGE;
									done_q       <= 1'b1;
								end else begin
									a_q     <= atom_index;
									state_q <= S_F0;
								end
							end
							default: begin
								res_status_q <= ST_RANGE;
								done_q       <= 1'b1;
							end
						endcase
					end
				end
				S_SINIT, S_SRCH: begin
					if (srch_fin) begin
						if (tbl_q) begin
							// shell found; chain into the atom search
							s_q     <= SW'(srch_idx);
							key_q   <= KW'(srch_idx);
							tbl_q   <= 1'b0;
							lo_q    <= '0;
							hi_q    <= IW'(atom_count_q - 1'b1);
							state_q <= S_SINIT;
						end else begin
							a_q     <= AW'(srch_idx);
							state_q <= S_F0;
						end
					end else if (state_q == S_SINIT) begin
						mid_q   <= init_mid;
						state_q <= S_SRCH;
					end else begin
						lo_q  <= nlo;
						hi_q  <= nhi;
						mid_q <= nmid;
					end
				end
				S_F0: begin
					state_q <= S_F1;
				end
				S_F1: begin
					ss_top_q <= ss_rdata;
					fs_top_q <= fs_rdata;
					state_q  <= S_F2;
				end
				S_F2: begin
					ss_base_q <= (a_q == '0) ? '0 : ss_rdata;
					fs_base_q <= (s_q == '0) ? '0 : fs_rdata;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					unique case (mode_q)
						MODE_ADD_SHELL: begin
							res_atom_q  <= a_q;
							res_sglob_q <= s_q;
							res_sloc_q  <= fin_sloc;
							res_soa_q   <= fin_soa;
							res_fos_q   <= cnt_q;
							res_fglob_q <= ftot_q;
							app_q       <= app_q + 1'b1;
							ftot_q      <= FW'(ftot_q + FW'(cnt_q));
						end
						MODE_FIND_FUNC: begin
							res_atom_q  <= a_q;
							res_sglob_q <= s_q;
							res_sloc_q  <= fin_sloc;
							res_soa_q   <= fin_soa;
							res_fos_q   <= CW'(fin_fos);
							res_fglob_q <= fi_q;
							res_floc_q  <= fi_q - fs_base_q;
						end
						MODE_FIND_SHELL: begin
							res_atom_q  <= a_q;
							res_sglob_q <= s_q;
							res_sloc_q  <= fin_sloc;
							res_soa_q   <= fin_soa;
							if (s_hit) begin
								res_fos_q   <= CW'(fin_fos);
								res_fglob_q <= fs_base_q;
							end
						end
						MODE_TO_GLOBAL: begin
							if (!phase_q) begin
								if (SCW'(si_q) >= fin_soa) begin
									res_status_q <= ST_RANGE;
								end else begin
									// refetch with the global shell now known
									s_q     <= SW'(ss_base_q + SCW'(si_q));
									phase_q <= 1'b1;
									state_q <= S_F0;
									done_q  <= 1'b0;
								end
							end else if (fi_q >= fin_fos_v) begin
								res_status_q <= ST_RANGE;
							end else begin
								res_atom_q  <= a_q;
								res_sloc_q  <= si_q;
								res_sglob_q <= s_q;
								res_floc_q  <= fi_q;
								res_fglob_q <= fs_base_q + fi_q;
								res_soa_q   <= fin_soa;
								res_fos_q   <= CW'(fin_fos_v);
							end
						end
						default: begin
							res_status_q <= ST_RANGE;
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy               = (state_q != S_IDLE);
	assign done               = done_q;
	assign status             = res_status_q;
	assign atom_found         = res_atom_q;
	assign shell_local        = res_sloc_q;
	assign shell_global       = res_sglob_q;
	assign function_local     = res_floc_q;
	assign function_global    = res_fglob_q;
	assign shells_of_atom     = res_soa_q;
	assign functions_of_shell = res_fos_q;
	assign atoms_total        = atom_count_q;
	assign shells_total       = shell_count_q;
	assign functions_total    = ftot_q;

	`RTLIM_ASSERT_IMPL(a_app_le_declared, clk, arst_n, 1'b1, app_q <= shell_count_q)
	`RTLIM_ASSERT_IMPL(a_counts_bounded, clk, arst_n, 1'b1, (shell_count_q <= SCW'(MAX_SHELLS)) && (atom_count_q <= ACW'(MAX_ATOMS)))
	`RTLIM_ASSERT_IMPL(a_search_window, clk, arst_n, state_q == S_SRCH, (lo_q <= mid_q) && (mid_q < hi_q))
	`RTLIM_ASSERT_IMPL(a_fs_write_at_fin, clk, arst_n, fs_we, (state_q == S_FIN) && (mode_q == MODE_ADD_SHELL))
	`RTLIM_ASSERT_NEXT(a_no_spurious_done, clk, arst_n, (state_q == S_IDLE) && !start, !done_q)

endmodule

/* rtl/core/ragged_two_level_index_mapper.sv */
`timescale 1ns / 1ps

// Ragged two-level index mapper. Atoms are appended with their shell counts
// and shells, in global order, with their function counts; the block keeps
// inclusive running sums of both in two single-port synchronous RAMs and
// answers lookups between global function / shell numbers and the
// (atom, local shell, local function) triple. Drive start with an item while
// busy is low; the transfer happens on that edge. The result appears for
// exactly one cycle with done high and must be taken then: there is no
// backpressure. Clear, append atom and every check that fails at entry
// answer in the cycle after start. Other modes walk the tables with binary
// searches, one RAM read per step, followed by a fetch of the located
// entries through states F0, F1 and F2 and a final state FIN; local to
// global makes two fetch passes. A new start is taken in the cycle done is
// high. The tables hold stale data after reset or clear, which never reaches
// a result: entries at or above the running counts may be read, but their
// data is not used.
module ragged_two_level_index_mapper #(
	parameter int MAX_ATOMS     = rtlim_pkg::MAX_ATOMS_DEF,
	parameter int MAX_SHELLS    = rtlim_pkg::MAX_SHELLS_DEF,
	parameter int FUNCTION_BITS = rtlim_pkg::FUNCTION_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic [rtlim_pkg::MODE_W-1:0]              mode,
	input  logic [rtlim_pkg::idx_w(MAX_ATOMS)-1:0]    atom_index,
	input  logic [rtlim_pkg::idx_w(MAX_SHELLS)-1:0]   shell_index,
	input  logic [FUNCTION_BITS-1:0]                  function_index,
	input  logic [rtlim_pkg::COUNT_W-1:0]             count,
	output logic                                      done,
	output logic [rtlim_pkg::STATUS_W-1:0]            status,
	output logic [rtlim_pkg::idx_w(MAX_ATOMS)-1:0]    atom_found,
	output logic [rtlim_pkg::idx_w(MAX_SHELLS)-1:0]   shell_local,
	output logic [rtlim_pkg::idx_w(MAX_SHELLS)-1:0]   shell_global,
	output logic [FUNCTION_BITS-1:0]                  function_local,
	output logic [FUNCTION_BITS-1:0]                  function_global,
	output logic [rtlim_pkg::cnt_w(MAX_SHELLS)-1:0]   shells_of_atom,
	output logic [rtlim_pkg::COUNT_W-1:0]             functions_of_shell,
	output logic [rtlim_pkg::cnt_w(MAX_ATOMS)-1:0]    atoms_total,
	output logic [rtlim_pkg::cnt_w(MAX_SHELLS)-1:0]   shells_total,
	output logic [FUNCTION_BITS-1:0]                  functions_total
);

	import rtlim_pkg::*;

	localparam int AW  = idx_w(MAX_ATOMS);
	localparam int SW  = idx_w(MAX_SHELLS);
	localparam int SCW = cnt_w(MAX_SHELLS);

	// shell-sum table: one entry per atom, inclusive shell count
	logic           ss_we;
	logic [AW-1:0]  ss_addr;
	logic [SCW-1:0] ss_wdata;
	logic [SCW-1:0] ss_rdata;

	// function-sum table: one entry per shell, inclusive function count
	logic                     fs_we;
	logic [SW-1:0]            fs_addr;
	logic [FUNCTION_BITS-1:0] fs_wdata;
	logic [FUNCTION_BITS-1:0] fs_rdata;

	// Sequencer: checks, binary searches, fetch and write-back. Each item
	// runs to completion before the next start, and a table write lands at
	// the edge that ends the item, so no read of a later item can see a
	// half-written entry.
	rtlim_seq #(
		.MAX_ATOMS     (MAX_ATOMS),
		.MAX_SHELLS    (MAX_SHELLS),
		.FUNCTION_BITS (FUNCTION_BITS)
	) u_seq (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.mode               (mode),
		.atom_index         (atom_index),
		.shell_index        (shell_index),
		.function_index     (function_index),
		.count              (count),
		.done               (done),
		.status             (status),
		.atom_found         (atom_found),
		.shell_local        (shell_local),
		.shell_global       (shell_global),
		.function_local     (function_local),
		.function_global    (function_global),
		.shells_of_atom     (shells_of_atom),
		.functions_of_shell (functions_of_shell),
		.atoms_total        (atoms_total),
		.shells_total       (shells_total),
		.functions_total    (functions_total),
		.ss_we              (ss_we),
		.ss_addr            (ss_addr),
		.ss_wdata           (ss_wdata),
		.ss_rdata           (ss_rdata),
		.fs_we              (fs_we),
		.fs_addr            (fs_addr),
		.fs_wdata           (fs_wdata),
		.fs_rdata           (fs_rdata)
	);

	rtlim_ram #(
		.WIDTH (SCW),
		.DEPTH (MAX_ATOMS)
	) u_shell_sum (
		.clk   (clk),
		.we    (ss_we),
		.addr  (ss_addr),
		.wdata (ss_wdata),
		.rdata (ss_rdata)
	);

	rtlim_ram #(
		.WIDTH (FUNCTION_BITS),
		.DEPTH (MAX_SHELLS)
	) u_func_sum (
		.clk   (clk),
		.we    (fs_we),
		.addr  (fs_addr),
		.wdata (fs_wdata),
		.rdata (fs_rdata)
	);

endmodule

/* verif/ragged_two_level_index_mapper_tb.sv */
`timescale 1ns / 1ps

module ragged_two_level_index_mapper_tb;
	import rtlim_pkg::*;

	localparam int N_ATOMS     = MAX_ATOMS_DEF;
	localparam int N_SHELLS    = MAX_SHELLS_DEF;
	localparam int FUNC_LIMIT  = (1 << FUNCTION_BITS_DEF) - 1;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 40;
	localparam int RUN_ITEMS   = 650;

	// modes the block must reject
	localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  ai;
		logic [9:0]  si;
		logic [15:0] fi;
		logic [9:0]  cnt;
		logic        drain;
		logic [6:0]  gap_pct;
	} mapper_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  atom_found;
		logic [9:0]  shell_local;
		logic [9:0]  shell_global;
		logic [15:0] function_local;
		logic [15:0] function_global;
		logic [10:0] shells_of_atom;
		logic [9:0]  functions_of_shell;
		logic [8:0]  atoms_total;
		logic [10:0] shells_total;
		logic [15:0] functions_total;
	} mapper_result_t;

	logic        clk;
	logic        arst_n;
	logic        start = 1'b0;
	logic [2:0]  mode = 3'd0;
	logic [7:0]  atom_index = 8'd0;
	logic [9:0]  shell_index = 10'd0;
	logic [15:0] function_index = 16'd0;
	logic [9:0]  count = 10'd0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [7:0]  atom_found;
	logic [9:0]  shell_local;
	logic [9:0]  shell_global;
	logic [15:0] function_local;
	logic [15:0] function_global;
	logic [10:0] shells_of_atom;
	logic [9:0]  functions_of_shell;
	logic [8:0]  atoms_total;
	logic [10:0] shells_total;
	logic [15:0] functions_total;

	ragged_two_level_index_mapper DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.mode               (mode),
		.atom_index         (atom_index),
		.shell_index        (shell_index),
		.function_index     (function_index),
		.count              (count),
		.done               (done),
		.status             (status),
		.atom_found         (atom_found),
		.shell_local        (shell_local),
		.shell_global       (shell_global),
		.function_local     (function_local),
		.function_global    (function_global),
		.shells_of_atom     (shells_of_atom),
		.functions_of_shell (functions_of_shell),
		.atoms_total        (atoms_total),
		.shells_total       (shells_total),
		.functions_total    (functions_total)
	);

	// Commands waiting to be driven, and the lookups they must produce.
	mapper_cmd_t    pending_cmds[$];
	mapper_result_t expected_results[$];

	int failures = 0;
	int issued_cnt = 0;
	int returned_cnt = 0;
	int stall_cycles = 0;
	int ops_seen[8];
	int status_seen[4];

	// Predicted table contents: inclusive running sums and the three counts.
	int tab_shell_sum[N_ATOMS];
	int tab_func_sum[N_SHELLS];
	int n_atoms = 0;
	int n_shells = 0;
	int n_appended = 0;

	// Layout the stimulus believes it has built, used to aim lookups at real entries.
	int plan_atoms = 0;
	int plan_shells = 0;
	int plan_app = 0;
	int plan_ftot = 0;
	int plan_total = 0;
	int plan_first_shell[N_ATOMS];
	int plan_atom_shells[N_ATOMS];
	int plan_shell_funcs[N_SHELLS];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_failure(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		failures++;
	endtask

	function automatic int functions_sum_total();
		return (n_appended == 0) ? 0 : tab_func_sum[n_appended - 1];
	endfunction

	function automatic int atom_shell_base(input int a);
		return (a == 0) ? 0 : tab_shell_sum[a - 1];
	endfunction

	function automatic int shell_func_base(input int s);
		return (s == 0) ? 0 : tab_func_sum[s - 1];
	endfunction

	// First atom whose running shell sum passes s; empty atoms are skipped.
	function automatic int atom_owning(input int s);
		int a;
		a = 0;
		while (a + 1 < n_atoms && s >= tab_shell_sum[a])
			a++;
		return a;
	endfunction

	// First appended shell whose running function sum passes f.
	function automatic int shell_owning(input int f);
		int s;
		s = 0;
		while (s + 1 < n_appended && f >= tab_func_sum[s])
			s++;
		return s;
	endfunction

	// Apply one command to the predicted tables and return the lookup it yields.
	function automatic mapper_result_t predict_mapping(input logic [2:0] op, input int ai,
			input int si, input int fi, input int cnt);
		mapper_result_t r;
		int a, s, b, ft, soa, fos;
		r = '0;
		case (op)
		MODE_CLEAR: begin
			n_atoms = 0;
			n_shells = 0;
			n_appended = 0;
		end
		MODE_ADD_ATOM: begin
			if (n_atoms >= N_ATOMS || n_shells + cnt > N_SHELLS) begin
				r.status = ST_FULL;
			end else begin
				r.atom_found = 8'(n_atoms);
				r.shell_global = 10'(n_shells);
				r.shells_of_atom = 11'(cnt);
				n_shells += cnt;
				tab_shell_sum[n_atoms] = n_shells;
				n_atoms++;
			end
		end
		MODE_ADD_SHELL: begin
			ft = functions_sum_total();
			if (n_appended >= n_shells || n_appended >= N_SHELLS || ft + cnt > FUNC_LIMIT) begin
				r.status = ST_FULL;
			end else begin
				s = n_appended;
				a = atom_owning(s);
				b = atom_shell_base(a);
				r.atom_found = 8'(a);
				r.shell_global = 10'(s);
				r.shell_local = 10'(s - b);
				r.shells_of_atom = 11'(tab_shell_sum[a] - b);
				r.functions_of_shell = 10'(cnt);
				r.function_global = 16'(ft);
				tab_func_sum[s] = ft + cnt;
				n_appended++;
			end
		end
		MODE_FIND_FUNC: begin
			if (fi >= functions_sum_total()) begin
				r.status = ST_RANGE;
			end else begin
				s = shell_owning(fi);
				a = atom_owning(s);
				b = atom_shell_base(a);
				r.atom_found = 8'(a);
				r.shell_global = 10'(s);
				r.shell_local = 10'(s - b);
				r.shells_of_atom = 11'(tab_shell_sum[a] - b);
				r.functions_of_shell = 10'(tab_func_sum[s] - shell_func_base(s));
				r.function_global = 16'(fi);
				r.function_local = 16'(fi - shell_func_base(s));
			end
		end
		MODE_FIND_SHELL: begin
			if (si >= n_shells) begin
				r.status = ST_RANGE;
			end else begin
				a = atom_owning(si);
				b = atom_shell_base(a);
				r.atom_found = 8'(a);
				r.shell_global = 10'(si);
				r.shell_local = 10'(si - b);
				r.shells_of_atom = 11'(tab_shell_sum[a] - b);
				// a declared shell without its function count reads as empty
				if (si < n_appended) begin
					r.functions_of_shell = 10'(tab_func_sum[si] - shell_func_base(si));
					r.function_global = 16'(shell_func_base(si));
				end
			end
		end
		MODE_TO_GLOBAL: begin
			if (ai >= n_atoms) begin
				r.status = ST_RANGE;
			end else begin
				b = atom_shell_base(ai);
				soa = tab_shell_sum[ai] - b;
				s = b + si;
				fos = (si < soa && s < n_appended) ? tab_func_sum[s] - shell_func_base(s) : 0;
				if (si >= soa || fi >= fos) begin
					r.status = ST_RANGE;
				end else begin
					r.atom_found = 8'(ai);
					r.shell_local = 10'(si);
					r.shell_global = 10'(s);
					r.function_local = 16'(fi);
					r.function_global = 16'(shell_func_base(s) + fi);
					r.shells_of_atom = 11'(soa);
					r.functions_of_shell = 10'(fos);
				end
			end
		end
		default: r.status = ST_RANGE;
		endcase
		r.atoms_total = 9'(n_atoms);
		r.shells_total = 11'(n_shells);
		r.functions_total = 16'(functions_sum_total());
		return r;
	endfunction

	// Queue one command and track the layout it should build. Idling comes in
	// stretches of 60 commands: none, heavy, light.
	task automatic queue_cmd(input logic [2:0] op, input int ai, input int si, input int fi,
			input int cnt, input bit drain);
		mapper_cmd_t c;
		c.op = op;
		c.ai = 8'(ai);
		c.si = 10'(si);
		c.fi = 16'(fi);
		c.cnt = 10'(cnt);
		c.drain = drain;
		case ((plan_total / 60) % 3)
			0: c.gap_pct = 7'd0;
			1: c.gap_pct = 7'd57;
			default: c.gap_pct = 7'd20;
		endcase
		pending_cmds.push_back(c);
		plan_total++;
		case (op)
		MODE_CLEAR: begin
			plan_atoms = 0;
			plan_shells = 0;
			plan_app = 0;
			plan_ftot = 0;
		end
		MODE_ADD_ATOM: begin
			if (plan_atoms < N_ATOMS && plan_shells + c.cnt <= N_SHELLS) begin
				plan_first_shell[plan_atoms] = plan_shells;
				plan_atom_shells[plan_atoms] = c.cnt;
				plan_shells += c.cnt;
				plan_atoms++;
			end
		end
		MODE_ADD_SHELL: begin
			if (plan_app < plan_shells && plan_ftot + c.cnt <= FUNC_LIMIT) begin
				plan_shell_funcs[plan_app] = c.cnt;
				plan_ftot += c.cnt;
				plan_app++;
			end
		end
		default: ;
		endcase
	endtask

	// Append or clear with the fields the mode ignores filled at random.
	task automatic queue_op(input logic [2:0] op, input int cnt, input bit drain);
		queue_cmd(op, $urandom_range(0, 255), $urandom_range(0, 1023),
			$urandom_range(0, 65535), cnt, drain);
	endtask

	// One lookup, mostly aimed inside the built tables, sometimes just past an edge.
	task automatic queue_lookup(input bit drain);
		int pick, a, si, fi, s, nf;
		bit stray;
		pick = $urandom_range(0, 2);
		stray = ($urandom_range(0, 4) == 0);
		if (pick == 0) begin
			if (stray || plan_ftot == 0)
				fi = $urandom_range(0, 1) ? plan_ftot : $urandom_range(0, 65535);
			else
				fi = $urandom_range(0, plan_ftot - 1);
			queue_cmd(MODE_FIND_FUNC, $urandom_range(0, 255), $urandom_range(0, 1023), fi,
				$urandom_range(0, 1023), drain);
		end else if (pick == 1) begin
			if (stray || plan_shells == 0)
				si = $urandom_range(0, 1) ? plan_shells : $urandom_range(0, 1023);
			else
				si = $urandom_range(0, plan_shells - 1);
			queue_cmd(MODE_FIND_SHELL, $urandom_range(0, 255), si, $urandom_range(0, 65535),
				$urandom_range(0, 1023), drain);
		end else begin
			a = (plan_atoms == 0) ? 0 : $urandom_range(0, plan_atoms - 1);
			si = (plan_atom_shells[a] == 0) ? 0 : $urandom_range(0, plan_atom_shells[a] - 1);
			s = plan_first_shell[a] + si;
			nf = (s < plan_app) ? plan_shell_funcs[s] : 0;
			fi = (nf == 0) ? 0 : $urandom_range(0, nf - 1);
			if (stray) begin
				case ($urandom_range(0, 2))
					0: a = plan_atoms;
					1: si = plan_atom_shells[a];
					default: fi = nf;
				endcase
			end
			queue_cmd(MODE_TO_GLOBAL, a, si, fi, $urandom_range(0, 1023), drain);
		end
	endtask

	// Driver: on each edge book the transfer that just happened, then hold,
	// present the next command, or idle. start gets at most one assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		mapper_cmd_t nxt;
		int took;
		if (!arst_n) begin
			start <= 1'b0;
			mode <= MODE_CLEAR;
			atom_index <= '0;
			shell_index <= '0;
			function_index <= '0;
			count <= '0;
			issued_cnt <= 0;
		end else begin
			took = (start && !busy) ? 1 : 0;
			if (took != 0) begin
				expected_results.push_back(predict_mapping(mode, atom_index, shell_index,
					function_index, count));
				ops_seen[mode]++;
			end
			issued_cnt <= issued_cnt + took;
			if (start && took == 0) begin
				// hold the command until busy drops
			end else if (pending_cmds.size() != 0 &&
					!(pending_cmds[0].drain && returned_cnt != issued_cnt + took) &&
					$urandom_range(0, 99) >= pending_cmds[0].gap_pct) begin
				nxt = pending_cmds.pop_front();
				start <= 1'b1;
				mode <= nxt.op;
				atom_index <= nxt.ai;
				shell_index <= nxt.si;
				function_index <= nxt.fi;
				count <= nxt.cnt;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: take each strobed result and compare it with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		mapper_result_t want;
		if (!arst_n) begin
			returned_cnt <= 0;
		end else if (done) begin
			status_seen[status]++;
			if (expected_results.size() == 0) begin
				report_failure("result strobed with no transfer outstanding");
			end else begin
				want = expected_results.pop_front();
				returned_cnt <= returned_cnt + 1;
				if (status !== want.status)
					report_failure($sformatf("status %0d, expected %0d", status, want.status));
				if (atom_found !== want.atom_found)
					report_failure($sformatf("atom_found %0d, expected %0d",
						atom_found, want.atom_found));
				if (shell_local !== want.shell_local)
					report_failure($sformatf("shell_local %0d, expected %0d",
						shell_local, want.shell_local));
				if (shell_global !== want.shell_global)
					report_failure($sformatf("shell_global %0d, expected %0d",
						shell_global, want.shell_global));
				if (function_local !== want.function_local)
					report_failure($sformatf("function_local %0d, expected %0d",
						function_local, want.function_local));
				if (function_global !== want.function_global)
					report_failure($sformatf("function_global %0d, expected %0d",
						function_global, want.function_global));
				if (shells_of_atom !== want.shells_of_atom)
					report_failure($sformatf("shells_of_atom %0d, expected %0d",
						shells_of_atom, want.shells_of_atom));
				if (functions_of_shell !== want.functions_of_shell)
					report_failure($sformatf("functions_of_shell %0d, expected %0d",
						functions_of_shell, want.functions_of_shell));
				if (atoms_total !== want.atoms_total)
					report_failure($sformatf("atoms_total %0d, expected %0d",
						atoms_total, want.atoms_total));
				if (shells_total !== want.shells_total)
					report_failure($sformatf("shells_total %0d, expected %0d",
						shells_total, want.shells_total));
				if (functions_total !== want.functions_total)
					report_failure($sformatf("functions_total %0d, expected %0d",
						functions_total, want.functions_total));
			end
		end
	end

	// Watchdog: drop the run if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no transfer or result for %0d cycles", STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int n, k, i, c;
		arst_n = 1'b0;

		// Directed: empty tables, rejected modes, empty atoms and shells,
		// a declared shell not yet appended, both full conditions, the edges
		// of every index, and a clear followed by one more lookup.
		queue_cmd(MODE_FIND_FUNC, 0, 0, 0, 0, 0);
		queue_cmd(MODE_FIND_SHELL, 0, 0, 0, 0, 0);
		queue_cmd(MODE_TO_GLOBAL, 0, 0, 0, 0, 0);
		queue_cmd(MODE_ADD_SHELL, 0, 0, 0, 5, 0);
		queue_cmd(MODE_BAD_LO, 255, 1023, 65535, 1023, 0);
		queue_cmd(MODE_BAD_HI, 0, 0, 0, 0, 0);
		queue_cmd(MODE_ADD_ATOM, 0, 0, 0, 0, 0);
		queue_cmd(MODE_ADD_ATOM, 0, 0, 0, 3, 0);
		queue_cmd(MODE_ADD_ATOM, 0, 0, 0, 0, 0);
		queue_cmd(MODE_ADD_ATOM, 0, 0, 0, 2, 0);
		queue_cmd(MODE_ADD_SHELL, 0, 0, 0, 0, 0);
		queue_cmd(MODE_ADD_SHELL, 0, 0, 0, 4, 0);
		queue_cmd(MODE_ADD_SHELL, 0, 0, 0, 1023, 0);
		queue_cmd(MODE_ADD_SHELL, 0, 0, 0, 2, 0);
		queue_cmd(MODE_FIND_SHELL, 0, 4, 0, 0, 1);
		queue_cmd(MODE_TO_GLOBAL, 3, 1, 0, 0, 0);
		queue_cmd(MODE_ADD_SHELL, 0, 0, 0, 7, 0);
		queue_cmd(MODE_ADD_SHELL, 0, 0, 0, 1, 0);
		queue_cmd(MODE_FIND_FUNC, 0, 0, 0, 0, 0);
		queue_cmd(MODE_FIND_FUNC, 0, 0, 1035, 0, 0);
		queue_cmd(MODE_FIND_FUNC, 0, 0, 65535, 0, 0);
		queue_cmd(MODE_FIND_SHELL, 0, 1023, 0, 0, 0);
		queue_cmd(MODE_TO_GLOBAL, 255, 0, 0, 0, 0);
		queue_cmd(MODE_TO_GLOBAL, 1, 2, 1022, 0, 0);
		queue_cmd(MODE_TO_GLOBAL, 1, 0, 0, 0, 0);
		queue_cmd(MODE_ADD_ATOM, 0, 0, 0, 1023, 0);
		queue_cmd(MODE_ADD_ATOM, 0, 0, 0, 1019, 0);
		queue_cmd(MODE_ADD_ATOM, 0, 0, 0, 0, 0);
		queue_cmd(MODE_CLEAR, 0, 0, 0, 0, 0);
		queue_cmd(MODE_FIND_SHELL, 0, 0, 0, 0, 0);

		// Fill the atom table past its last entry, then search across it.
		queue_op(MODE_CLEAR, 0, 1);
		repeat (N_ATOMS + 2)
			queue_op(MODE_ADD_ATOM, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0, 0);
		repeat (20) queue_op(MODE_ADD_SHELL, $urandom_range(0, 30), 0);
		repeat (15) queue_lookup(0);

		// Push the function sum past its limit.
		queue_op(MODE_CLEAR, 0, 0);
		queue_op(MODE_ADD_ATOM, 100, 0);
		repeat (70)
			queue_op(MODE_ADD_SHELL, ($urandom_range(0, 4) == 0) ? $urandom_range(900, 1023) : 1023, 0);
		repeat (15) queue_lookup(0);
		queue_op(MODE_ADD_ATOM, 1023, 0);

		// Well-formed builds with random content, plus bursts of raw noise.
		while (plan_total < RUN_ITEMS) begin
			if ($urandom_range(0, 99) < 78) begin
				queue_op(MODE_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 2) == 0);
				n = $urandom_range(1, 8);
				repeat (n)
					queue_op(MODE_ADD_ATOM, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6), 0);
				k = plan_shells + $urandom_range(0, 1);
				if ($urandom_range(0, 3) == 0)
					k -= $urandom_range(0, 2);
				for (i = 0; i < k; i++) begin
					case ($urandom_range(0, 19))
						0, 1: c = 0;
						2: c = 1023;
						default: c = $urandom_range(1, 40);
					endcase
					queue_op(MODE_ADD_SHELL, c, 0);
					if ($urandom_range(0, 3) == 0)
						queue_lookup(0);
				end
				n = $urandom_range(6, 14);
				for (i = 0; i < n; i++)
					queue_lookup(i == 0 && $urandom_range(0, 2) == 0);
			end else begin
				repeat ($urandom_range(4, 8))
					queue_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 255),
						$urandom_range(0, 1023), $urandom_range(0, 65535),
						$urandom_range(0, 1023), 0);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Sample at the falling edge so the driver and monitor have settled.
		do @(negedge clk);
		while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_results.size() != 0)
			report_failure($sformatf("%0d results never arrived", expected_results.size()));

		$display("Covered %0d transfers: %0d clear, %0d atom, %0d shell appends; lookups %0d/%0d/%0d; %0d bad mode",
			issued_cnt, ops_seen[MODE_CLEAR], ops_seen[MODE_ADD_ATOM], ops_seen[MODE_ADD_SHELL],
			ops_seen[MODE_FIND_FUNC], ops_seen[MODE_FIND_SHELL], ops_seen[MODE_TO_GLOBAL],
			ops_seen[MODE_BAD_LO] + ops_seen[MODE_BAD_HI]);
		$display("Results seen: %0d ok, %0d out of range, %0d full; %0d mismatches",
			status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL], failures);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
